>>> rtl/pbsa_pkg.sv
// shared types, codes and constants of the priority batch slot allocator
package pbsa_pkg;

    // default slot count
    localparam int SLOTS_DEF = 8;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_TYPES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_PERCENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_CAPACITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES   = 3'd4;

    // register reset values
    localparam logic [31:0] PRIO_RESET     = 32'h0000_3800;
    localparam logic [6:0]  RATIO_RESET    = 7'd80;
    localparam logic [6:0]  ACTIVE_RESET   = 7'd3;
    localparam logic [20:0] CAPACITY_RESET = 21'h10_0000;
    localparam logic [12:0] HEADER_RESET   = 13'd64;

    // result outcome codes
    localparam logic [2:0] OUT_APPEND  = 3'd0;
    localparam logic [2:0] OUT_NEW     = 3'd1;
    localparam logic [2:0] OUT_REPLACE = 3'd2;
    localparam logic [2:0] OUT_FULL    = 3'd3;
    localparam logic [2:0] OUT_NONE    = 3'd4;

    // per-slot decision codes
    typedef logic [2:0] dec_t;
    localparam dec_t DEC_NEXT    = 3'd0;  // skip, keep scanning
    localparam dec_t DEC_MARK    = 3'd1;  // mark type full, keep scanning
    localparam dec_t DEC_STOP    = 3'd2;  // mark type full, end scan unplaced
    localparam dec_t DEC_FAIL    = 3'd3;  // end scan unplaced, no change
    localparam dec_t DEC_OPEN    = 3'd4;
    localparam dec_t DEC_APPEND  = 3'd5;
    localparam dec_t DEC_REPLACE = 3'd6;

    // barrier = prod / 100 done as (prod * 5243) >> 19, exact for prod below 8192
    localparam int          PROD_W      = 13;
    localparam int          SCALED_W    = 26;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [4:0]  stype;
        logic [31:0] group;
        logic [31:0] backend;
        logic [20:0] used;
    } slot_rec_t;

    localparam int SLOT_REC_W = $bits(slot_rec_t);

    typedef struct packed {
        logic [4:0]  stype;
        logic [31:0] group;
        logic [31:0] backend;
        logic [16:0] len8;
        logic [17:0] fresh;
        logic        fav;
    } req_t;

    typedef struct packed {
        dec_t        dec;
        logic [20:0] new_used;
    } eval_t;

endpackage

>>> rtl/pbsa_ram.sv
// generic single-write, single-read ram with registered read data
module pbsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pbsa_slot_eval.sv
// shared compare unit: judges one slot against the current request
module pbsa_slot_eval
    import pbsa_pkg::*;
(
    input  slot_rec_t   rec,
    input  logic        valid,
    input  req_t        req,
    input  logic [20:0] capacity,
    input  logic [31:0] prio_types,
    input  logic [6:0]  idx,
    input  logic [6:0]  barrier,
    output eval_t       result
);

    logic [21:0] sum;
    logic        fresh_too_big;
    logic        same_owner;

    assign sum           = {1'b0, rec.used} + 22'(req.len8);
    assign fresh_too_big = {3'b000, req.fresh} > capacity;
    assign same_owner    = (rec.group == req.group) && (rec.backend == req.backend);

    always_comb
    begin
        result.new_used = sum[20:0];
        if (!valid)
        begin
            result.dec = fresh_too_big ? DEC_FAIL : DEC_OPEN;
        end
        else if (rec.stype == req.stype)
        begin
            if (same_owner && (sum <= {1'b0, capacity}))
            begin
                result.dec = DEC_APPEND;
            end
            else
            begin
                result.dec = DEC_NEXT;
            end
        end
        else if (!prio_types[rec.stype] && req.fav)
        begin
            // eviction of a lower-class slot, only up to the barrier
            if (idx > barrier)
            begin
                result.dec = DEC_STOP;
            end
            else
            begin
                result.dec = fresh_too_big ? DEC_FAIL : DEC_REPLACE;
            end
        end
        else
        begin
            result.dec = DEC_MARK;
        end
    end

endmodule

>>> rtl/priority_batch_slot_allocator_top.sv
// top level of the priority batch slot allocator: sequencer, slot table and registers
//
// Each transaction on the input channel either starts a new scan (op = 1: all slots
// emptied, full-type set and opened count cleared) or offers one request, which is
// placed into a table of SLOTS batch slots. Favoured types (bit set in priority_types)
// scan from slot 0 upward, others from the highest active slot downward; a favoured
// request may take over a slot of a non-favoured type only at or below the ratio
// barrier (n-1)*ratio_percent/100. Exactly one result transaction follows each input
// transaction. Timing: slot records sit in a one-port-read ram and are judged one slot
// per cycle by a single compare unit. An offer passes through the barrier product, the
// divide-by-100 and first ram read, one scan step per inspected slot, the hand-off of
// the result (held while the output register is full and stalled) and the return to
// idle to take the next transaction; a new scan, an offer of an already full type or
// zero active slots goes from the barrier product step straight to the hand-off. The
// input stalls for the whole of this; the result sits in an output register, so the
// next transaction can be taken while it waits. Configuration is to be written by the
// user through the plain write port while the block is idle; it does not enforce this.
module priority_batch_slot_allocator_top
    import pbsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [4:0]            req_kind,
    input  logic [31:0]           group_id,
    input  logic [31:0]           backend_id,
    input  logic [15:0]           item_length,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            outcome,
    output logic [5:0]            slot_index,
    output logic [6:0]            slots_opened
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;  // decode request, form barrier product
    localparam logic [2:0] S_BAR  = 3'd2;  // divide by 100, issue first slot read
    localparam logic [2:0] S_SCAN = 3'd3;  // judge one slot per cycle
    localparam logic [2:0] S_DONE = 3'd4;  // move result into the output register

    // configuration registers
    logic [31:0] prio_reg,   prio_next;
    logic [6:0]  ratio_reg,  ratio_next;
    logic [6:0]  active_reg, active_next;
    logic [20:0] cap_reg,    cap_next;
    logic [12:0] hdr_reg,    hdr_next;

    // control state
    logic [2:0]       state_reg,   state_next;
    logic [SLOTS-1:0] valid_reg,   valid_next;
    logic [31:0]      full_reg,    full_next;
    logic [6:0]       opened_reg,  opened_next;
    logic             out_valid_reg, out_valid_next;

    // request and scan payload
    logic              op_reg,      op_next;
    req_t              req_reg,     req_next;
    logic [CNT_W-1:0]  n_reg,       n_next;
    logic [PROD_W-1:0] prod_reg,    prod_next;
    logic [6:0]        barrier_reg, barrier_next;
    logic [IDX_W-1:0]  i_reg,       i_next;
    logic [IDX_W-1:0]  k_reg,       k_next;
    logic [2:0]        res_out_reg, res_out_next;
    logic [5:0]        res_idx_reg, res_idx_next;
    logic [2:0]        out_code_reg,  out_code_next;
    logic [5:0]        out_idx_reg,   out_idx_next;
    logic [6:0]        out_opened_reg, out_opened_next;

    // slot table ram
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    slot_rec_t        ram_wdata;
    slot_rec_t        ram_rdata;

    // datapath helpers
    eval_t               ev;
    logic [16:0]         len8;
    logic [6:0]          n_clip;
    logic [CNT_W-1:0]    nm1;
    logic [SCALED_W-1:0] scaled;
    logic [6:0]          quot;
    logic [IDX_W-1:0]    i_first;
    logic [IDX_W-1:0]    i_step;
    logic                last_slot;
    logic                can_load;

    pbsa_ram #(
        .WIDTH (SLOT_REC_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (i_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pbsa_slot_eval u_eval (
        .rec        (ram_rdata),
        .valid      (valid_reg[i_reg]),
        .req        (req_reg),
        .capacity   (cap_reg),
        .prio_types (prio_reg),
        .idx        (7'(i_reg)),
        .barrier    (barrier_reg),
        .result     (ev)
    );

    // request length rounded up to eight bytes
    assign len8 = (17'(item_length) + 17'd7) & ~17'd7;

    // slots in use, clipped to the table size
    assign n_clip = (active_reg > 7'(SLOTS)) ? 7'(SLOTS) : active_reg;
    assign nm1    = n_reg - CNT_W'(1);

    assign scaled = SCALED_W'(prod_reg) * SCALED_W'(RECIP_100);
    assign quot   = scaled[RECIP_SHIFT +: 7];

    assign i_first   = req_reg.fav ? '0 : nm1[IDX_W-1:0];
    assign i_step    = req_reg.fav ? (i_reg + IDX_W'(1)) : (i_reg - IDX_W'(1));
    assign last_slot = (k_reg == nm1[IDX_W-1:0]);
    assign ram_raddr = (state_reg == S_BAR) ? i_first : i_step;

    assign can_load  = !out_valid_reg || !out_stall;

    always_comb
    begin
        prio_next       = prio_reg;
        ratio_next      = ratio_reg;
        active_next     = active_reg;
        cap_next        = cap_reg;
        hdr_next        = hdr_reg;
        state_next      = state_reg;
        valid_next      = valid_reg;
        full_next       = full_reg;
        opened_next     = opened_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        n_next          = n_reg;
        prod_next       = prod_reg;
        barrier_next    = barrier_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        res_out_next    = res_out_reg;
        res_idx_next    = res_idx_reg;
        out_code_next   = out_code_reg;
        out_idx_next    = out_idx_reg;
        out_opened_next = out_opened_reg;
        ram_we          = 1'b0;
        ram_wdata       = '{stype: req_reg.stype, group: req_reg.group,
                            backend: req_reg.backend, used: 21'(req_reg.fresh)};

        // configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PRIORITY_TYPES: prio_next   = cfg_data[31:0];
                REG_RATIO_PERCENT:  ratio_next  = cfg_data[6:0];
                REG_ACTIVE_SLOTS:   active_next = cfg_data[6:0];
                REG_SLOT_CAPACITY:  cap_next    = cfg_data[20:0];
                REG_HEADER_BYTES:   hdr_next    = cfg_data[12:0];
                default:            ;
            endcase
        end

        // output register drains on a completed transaction
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = op;
                    req_next.stype   = req_kind;
                    req_next.group   = group_id;
                    req_next.backend = backend_id;
                    req_next.len8    = len8;
                    req_next.fresh   = 18'(hdr_reg) + 18'(len8);
                    req_next.fav     = prio_reg[req_kind];
                    n_next        = CNT_W'(n_clip);
                    state_next    = S_PREP;
                end
            end
            S_PREP:
            begin
                prod_next = PROD_W'(PROD_W'(nm1) * PROD_W'(ratio_reg));
                k_next    = '0;
                if (op_reg)
                begin
                    valid_next   = '0;
                    full_next    = '0;
                    opened_next  = '0;
                    res_out_next = OUT_NONE;
                    res_idx_next = '0;
                    state_next   = S_DONE;
                end
                else if (full_reg[req_reg.stype])
                begin
                    res_out_next = OUT_FULL;
                    res_idx_next = '0;
                    state_next   = S_DONE;
                end
                else if (n_reg == '0)
                begin
                    res_out_next = OUT_NONE;
                    res_idx_next = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_BAR;
                end
            end
            S_BAR:
            begin
                // barrier of 0 becomes 1, barrier equal to n becomes n-1
                if (quot == 7'd0)
                begin
                    barrier_next = 7'd1;
                end
                else if (quot == 7'(n_reg))
                begin
                    barrier_next = quot - 7'd1;
                end
                else
                begin
                    barrier_next = quot;
                end
                i_next     = i_first;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                res_idx_next = '0;
                res_out_next = OUT_NONE;
                unique case (ev.dec) inside
                    DEC_OPEN:
                    begin
                        ram_we            = 1'b1;
                        valid_next[i_reg] = 1'b1;
                        opened_next       = opened_reg + 7'd1;
                        res_out_next      = OUT_NEW;
                        res_idx_next      = 6'(i_reg);
                        state_next        = S_DONE;
                    end
                    DEC_REPLACE:
                    begin
                        ram_we       = 1'b1;
                        res_out_next = OUT_REPLACE;
                        res_idx_next = 6'(i_reg);
                        state_next   = S_DONE;
                    end
                    DEC_APPEND:
                    begin
                        ram_we         = 1'b1;
                        ram_wdata      = ram_rdata;
                        ram_wdata.used = ev.new_used;
                        res_out_next   = OUT_APPEND;
                        res_idx_next   = 6'(i_reg);
                        state_next     = S_DONE;
                    end
                    DEC_FAIL:
                    begin
                        state_next = S_DONE;
                    end
                    DEC_STOP:
                    begin
                        full_next[req_reg.stype] = 1'b1;
                        state_next               = S_DONE;
                    end
                    DEC_MARK, DEC_NEXT:
                    begin
                        if (ev.dec == DEC_MARK)
                        begin
                            full_next[req_reg.stype] = 1'b1;
                        end
                        if (last_slot)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            i_next = i_step;
                            k_next = k_reg + IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_code_next   = res_out_reg;
                    out_idx_next    = res_idx_reg;
                    out_opened_next = opened_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg      <= PRIO_RESET;
            ratio_reg     <= RATIO_RESET;
            active_reg    <= ACTIVE_RESET;
            cap_reg       <= CAPACITY_RESET;
            hdr_reg       <= HEADER_RESET;
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            full_reg      <= '0;
            opened_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prio_reg      <= prio_next;
            ratio_reg     <= ratio_next;
            active_reg    <= active_next;
            cap_reg       <= cap_next;
            hdr_reg       <= hdr_next;
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            full_reg      <= full_next;
            opened_reg    <= opened_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        n_reg          <= n_next;
        prod_reg       <= prod_next;
        barrier_reg    <= barrier_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        res_out_reg    <= res_out_next;
        res_idx_reg    <= res_idx_next;
        out_code_reg   <= out_code_next;
        out_idx_reg    <= out_idx_next;
        out_opened_reg <= out_opened_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign outcome      = out_code_reg;
    assign slot_index   = out_idx_reg;
    assign slots_opened = out_opened_reg;

    // a result only appears out of the hand-off state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result appeared without a finished transaction");

    // scan position stays inside the active slots
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(k_reg) < n_reg) && (CNT_W'(i_reg) < n_reg))
        else $error("scan ran past the active slots");

    // opening a slot marks it valid
    a_open_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && ev.dec == DEC_OPEN) |=> valid_reg[$past(i_reg)])
        else $error("opened slot not marked valid");

    // never more slots opened than exist
    a_opened_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        opened_reg <= 7'(SLOTS))
        else $error("opened count exceeds slot count");

endmodule
